FILE: hdl/itgm_pkg.sv
// Package for the intensity-to-glyph mapper.
// Holds the ramp table sizes, register indexes, text byte codes and the lead-byte length decode.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itgm_pkg;

   localparam int RAMP_ENTRIES    = 256;
   localparam int MAX_GLYPH_BYTES = 4;
   localparam int RAMP_AW         = $clog2(RAMP_ENTRIES);
   localparam int LEN_W           = $clog2(MAX_GLYPH_BYTES + 1);
   localparam int GLYPH_W         = 8 * MAX_GLYPH_BYTES;
   localparam int DIM_LIMIT       = 4096;

   localparam logic [1:0] CSR_RAMP_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_LOAD  = 1'b1;

   localparam logic [7:0] BYTE_NEWLINE    = 8'h0A;
   localparam logic [7:0] BYTE_TERMINATOR = 8'h00;

   typedef struct packed {
      logic [GLYPH_W-1:0] glyph;
      logic [LEN_W-1:0]   len;
   } glyph_entry_type;

   function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] lead);
      int len;
      len = 1;
      if ((lead & 8'hE0) == 8'hC0) begin
         len = 2;
      end else if ((lead & 8'hF0) == 8'hE0) begin
         len = 3;
      end else if ((lead & 8'hF8) == 8'hF0) begin
         len = 4;
      end
      if (len > MAX_GLYPH_BYTES) begin
         len = MAX_GLYPH_BYTES;
      end
      return LEN_W'(len);
   endfunction

endpackage

`default_nettype wire

FILE: hdl/intensity_to_glyph_mapper_core.sv
// Intensity-to-glyph mapper: ramp glyph table in a synchronous RAM, pixel to text byte stream.
// Depends on itgm_pkg.
// A pixel request reads the RAM into the read data register; its first byte is shown once
// that entry moves into the emitter. Throughput: one response byte per cycle while rsp_stall is
// low; a pixel yields 1 to 6 bytes, a load none, and a new pixel can be taken while the
// last one's bytes go out. The single output byte register sets the rate. Reset is synchronous
// and clears control state (lengths and dimensions to 1), not the glyph RAM or data registers.
`timescale 1ns / 1ps
`default_nettype none

module intensity_to_glyph_mapper_core
   import itgm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_write_enable,
   input  wire logic [1:0]   csr_index,
   input  wire logic [12:0]  csr_write_data,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         req_mode,
   input  wire logic [7:0]   req_intensity,
   input  wire logic [7:0]   req_glyph_slot,
   input  wire logic [31:0]  req_glyph_bytes,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last
);

   glyph_entry_type glyph_ram [RAMP_ENTRIES];
   glyph_entry_type rd_data_ff;
   glyph_entry_type wr_entry;

   logic [8:0]  ramp_length_ff, ramp_length_in;
   logic [12:0] image_width_ff, image_width_in;
   logic [12:0] image_height_ff, image_height_in;
   logic [11:0] col_ff, col_in;
   logic [11:0] row_ff, row_in;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_nl_ff, s1_nl_in;
   logic        s1_term_ff, s1_term_in;

   logic [GLYPH_W-1:0] em_glyph_ff, em_glyph_in;
   logic [LEN_W-1:0]   em_left_ff, em_left_in;
   logic               em_nl_ff, em_nl_in;
   logic               em_term_ff, em_term_in;

   logic               req_fire, pix_fire, load_fire, rsp_fire;
   logic               em_last, em_done, s1_move;
   logic [8:0]         rl_eff, idx_raw, idx_clamped;
   logic [16:0]        product;
   logic [RAMP_AW-1:0] rd_idx, wr_idx;
   logic [12:0]        w_eff, h_eff, col_plus, row_plus;
   logic               row_end, img_end;

   // configuration
   always_comb begin
      ramp_length_in  = ramp_length_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RAMP_LENGTH:  ramp_length_in  = csr_write_data[8:0];
            CSR_IMAGE_WIDTH:  image_width_in  = csr_write_data;
            CSR_IMAGE_HEIGHT: image_height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (ramp_length_ff == 9'd0) begin
         rl_eff = 9'd1;
      end else if (int'(ramp_length_ff) > RAMP_ENTRIES) begin
         rl_eff = 9'(RAMP_ENTRIES);
      end else begin
         rl_eff = ramp_length_ff;
      end
      if (image_width_ff == 13'd0) begin
         w_eff = 13'd1;
      end else if (int'(image_width_ff) > DIM_LIMIT) begin
         w_eff = 13'(DIM_LIMIT);
      end else begin
         w_eff = image_width_ff;
      end
      if (image_height_ff == 13'd0) begin
         h_eff = 13'd1;
      end else if (int'(image_height_ff) > DIM_LIMIT) begin
         h_eff = 13'(DIM_LIMIT);
      end else begin
         h_eff = image_height_ff;
      end
   end

   // request side
   assign req_fire  = req_valid & ~req_stall;
   assign pix_fire  = req_fire & (req_mode == MODE_PIXEL);
   assign load_fire = req_fire & (req_mode == MODE_LOAD) & (int'(req_glyph_slot) < RAMP_ENTRIES);

   assign product = {9'd0, req_intensity} * {8'd0, rl_eff};
   assign idx_raw = product[16:8];
   assign idx_clamped = (idx_raw >= rl_eff) ? (rl_eff - 9'd1) : idx_raw;
   assign rd_idx = RAMP_AW'(idx_clamped);
   assign wr_idx = RAMP_AW'(req_glyph_slot);

   assign wr_entry.glyph = req_glyph_bytes[GLYPH_W-1:0];
   assign wr_entry.len   = lead_length(req_glyph_bytes[7:0]);

   // one request per cycle, so a read never meets a write in the same cycle
   always_ff @(posedge clock) begin
      if (load_fire) begin
         glyph_ram[wr_idx] <= wr_entry;
      end
      if (pix_fire) begin
         rd_data_ff <= glyph_ram[rd_idx];
      end
   end

   // row and column position
   assign col_plus = {1'b0, col_ff} + 13'd1;
   assign row_plus = {1'b0, row_ff} + 13'd1;
   assign row_end  = col_plus >= w_eff;
   assign img_end  = row_end & (row_plus >= h_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (pix_fire) begin
         col_in = row_end ? 12'd0 : col_plus[11:0];
         if (row_end) begin
            row_in = img_end ? 12'd0 : row_plus[11:0];
         end
      end
   end

   // byte emitter
   assign rsp_valid = (em_left_ff != '0) | em_nl_ff | em_term_ff;
   assign em_last = ((em_left_ff == LEN_W'(1)) & ~em_nl_ff & ~em_term_ff)
                  | ((em_left_ff == '0) & em_nl_ff & ~em_term_ff)
                  | ((em_left_ff == '0) & ~em_nl_ff & em_term_ff);
   assign rsp_last = em_last;
   assign rsp_out_byte = (em_left_ff != '0) ? em_glyph_ff[7:0]
                       : (em_nl_ff ? BYTE_NEWLINE : BYTE_TERMINATOR);
   assign rsp_fire = rsp_valid & ~rsp_stall;
   assign em_done  = ~rsp_valid | (rsp_fire & em_last);
   assign s1_move  = s1_valid_ff & em_done;
   assign req_stall = s1_valid_ff & ~em_done;

   always_comb begin
      s1_valid_in = pix_fire | (s1_valid_ff & ~em_done);
      s1_nl_in    = s1_nl_ff;
      s1_term_in  = s1_term_ff;
      if (pix_fire) begin
         s1_nl_in   = row_end;
         s1_term_in = img_end;
      end
   end

   always_comb begin
      em_glyph_in = em_glyph_ff;
      em_left_in  = em_left_ff;
      em_nl_in    = em_nl_ff;
      em_term_in  = em_term_ff;
      if (s1_move) begin
         em_glyph_in = rd_data_ff.glyph;
         em_left_in  = rd_data_ff.len;
         em_nl_in    = s1_nl_ff;
         em_term_in  = s1_term_ff;
      end else if (rsp_fire) begin
         if (em_left_ff != '0) begin
            em_left_in  = em_left_ff - LEN_W'(1);
            em_glyph_in = em_glyph_ff >> 8;
         end else if (em_nl_ff) begin
            em_nl_in = 1'b0;
         end else begin
            em_term_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_length_ff  <= 9'd1;
         image_width_ff  <= 13'd1;
         image_height_ff <= 13'd1;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         s1_nl_ff        <= 1'b0;
         s1_term_ff      <= 1'b0;
         em_left_ff      <= '0;
         em_nl_ff        <= 1'b0;
         em_term_ff      <= 1'b0;
      end else begin
         ramp_length_ff  <= ramp_length_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
         s1_nl_ff        <= s1_nl_in;
         s1_term_ff      <= s1_term_in;
         em_left_ff      <= em_left_in;
         em_nl_ff        <= em_nl_in;
         em_term_ff      <= em_term_in;
      end
   end

   always_ff @(posedge clock) begin
      em_glyph_ff <= em_glyph_in;
   end

endmodule

`default_nettype wire

FILE: hdl/itgm_checker.sv
// Port-level checks for the intensity-to-glyph mapper, bound to the top level.
// Depends on intensity_to_glyph_mapper_core.
`timescale 1ns / 1ps
`default_nettype none

module itgm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   a_bytes_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("gap inside one request's bytes");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last)))
      else $error("stalled response changed");

endmodule

bind intensity_to_glyph_mapper_core itgm_checker u_itgm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last     (rsp_last)
);

`default_nettype wire
